FILE: design/aes128_block_cipher_assert.svh
// assertion macros for the aes-128 block cipher
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/aes_pkg.sv
// shared types, tables and round functions for the aes-128 block cipher
`default_nettype none
package aes_pkg;
  localparam int unsigned NumRounds  = 10;
  localparam int unsigned StoreDepth = 2 * (NumRounds + 1);
  localparam int unsigned KeyIdxW    = $clog2(StoreDepth);
  localparam int unsigned NumStages  = NumRounds + 1;

  localparam logic       ReqEncrypt = 1'b0;
  localparam logic       ReqDecrypt = 1'b1;
  localparam logic [0:0] CfgKeyHigh = 1'b0;
  localparam logic [0:0] CfgKeyLow  = 1'b1;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   dec;
    block_t data;
  } stage_t;

  function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1B;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // byte i of the block sits at bits 127-8i
  function automatic logic [7:0] gb(input block_t s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic block_t sub_bytes(input block_t s, input logic inv);
    block_t o;
    for (int i = 0; i < 16; i++) begin
      o[127 - 8 * i -: 8] = inv ? sbox_inv(gb(s, i)) : sbox_fwd(gb(s, i));
    end
    return o;
  endfunction

  function automatic block_t shift_rows(input block_t s, input logic inv);
    block_t o;
    int src;
    o = s;
    for (int r = 1; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          src = r + 4 * ((c - r + 4) % 4);
        end else begin
          src = r + 4 * ((c + r) % 4);
        end
        o[127 - 8 * (r + 4 * c) -: 8] = gb(s, src);
      end
    end
    return o;
  endfunction

  function automatic block_t mix_columns(input block_t s, input logic inv);
    block_t o;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] acc;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = gb(s, 4 * c + j);
        x2[j] = xt(a[j]);
        x4[j] = xt(x2[j]);
        x8[j] = xt(x4[j]);
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          acc = (x8[r] ^ x4[r] ^ x2[r])
              ^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4])
              ^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4])
              ^ (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
        end else begin
          acc = x2[r] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4] ^ a[(r + 2) % 4]
              ^ a[(r + 3) % 4];
        end
        o[127 - 8 * (4 * c + r) -: 8] = acc;
      end
    end
    return o;
  endfunction
endpackage
`default_nettype wire

FILE: design/aes_key_expand.sv
// round key expansion, one round key per cycle after each key write
`default_nettype none
module aes_key_expand import aes_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_idx_i,
  input  wire logic [63:0]          cfg_data_i,
  output logic [NumRounds:0][127:0] rk_o
);
  logic [127:0]          key_q, key_d;
  logic [NumRounds:0][127:0] rk_q;
  logic [3:0]            cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [127:0]          prev, nxt;
  logic [31:0]           t;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyHigh: key_d[127:64] = cfg_data_i;
        CfgKeyLow:  key_d[63:0]   = cfg_data_i;
        default:    key_d = key_q;
      endcase
    end
  end

  assign prev = rk_q[cnt_q - 4'd1];
  always_comb begin
    t = {prev[23:0], prev[31:24]};
    t = {sbox_fwd(t[31:24]), sbox_fwd(t[23:16]), sbox_fwd(t[15:8]), sbox_fwd(t[7:0])};
    t[31:24] = t[31:24] ^ rcon(cnt_q);
    nxt[127:96] = prev[127:96] ^ t;
    nxt[95:64]  = prev[95:64] ^ nxt[127:96];
    nxt[63:32]  = prev[63:32] ^ nxt[95:64];
    nxt[31:0]   = prev[31:0] ^ nxt[63:32];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (cfg_we_i) begin
      busy_d = 1'b1;
      cnt_d  = 4'd1;
    end else if (busy_q) begin
      if (cnt_q == 4'(NumRounds)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      busy_q <= 1'b0;
      cnt_q  <= 4'd1;
    end else begin
      key_q  <= key_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we_i) begin
      rk_q[0] <= key_d;
    end else if (busy_q) begin
      rk_q[cnt_q] <= nxt;
    end
  end

  assign rk_o = rk_q;
endmodule
`default_nettype wire

FILE: design/aes_round.sv
// one cipher round stage, encrypt or decrypt
`default_nettype none
module aes_round import aes_pkg::*; (
  input  wire stage_t       in_i,
  input  wire logic         last_i,
  input  wire logic [127:0] rk_i,
  output stage_t            out_o
);
  block_t f, d;
  always_comb begin
    f = shift_rows(sub_bytes(in_i.data, 1'b0), 1'b0);
    if (!last_i) begin
      f = mix_columns(f, 1'b0);
    end
    f = f ^ rk_i;
    d = sub_bytes(shift_rows(in_i.data, 1'b1), 1'b1) ^ rk_i;
    if (!last_i) begin
      d = mix_columns(d, 1'b1);
    end
    out_o.dec  = in_i.dec;
    out_o.data = in_i.dec ? d : f;
  end
endmodule
`default_nettype wire

FILE: design/aes128_block_cipher.sv
// aes-128 block cipher top level: key schedule and round pipeline
//
// Eleven-stage pipeline: an initial key-add stage followed by one stage per
// round; one block may enter every cycle while the pipe advances. The whole
// pipe advances only when its last stage is free or taken. After a key write
// the schedule builds the round keys in turn; the user must not present the
// first block before they are built, as the block itself does not enforce it.
`default_nettype none
module aes128_block_cipher import aes_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);
  logic [NumRounds:0][127:0] rk;
  stage_t [NumStages-1:0] st_q;
  stage_t [NumStages-1:0] st_d;
  logic   [NumStages-1:0] vld_q;
  logic                   adv;

  aes_key_expand u_key (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .rk_o(rk)
  );

  assign adv = !vld_q[NumStages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    st_d[0].dec  = req_type_i;
    st_d[0].data = {block_high_i, block_low_i} ^ (req_type_i ? rk[NumRounds] : rk[0]);
  end

  for (genvar g = 1; g < NumStages; g++) begin : g_rnd
    aes_round u_rnd (
      .in_i  (st_q[g-1]),
      .last_i(g == NumStages - 1),
      .rk_i  (st_q[g-1].dec ? rk[NumRounds - g] : rk[g]),
      .out_o (st_d[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
    end
  end

  assign out_valid_o   = vld_q[NumStages-1];
  assign result_high_o = st_q[NumStages-1].data[127:64];
  assign result_low_o  = st_q[NumStages-1].data[63:0];
endmodule
`default_nettype wire

FILE: design/aes128_block_cipher_checker.sv
// port-level checker for the aes-128 block cipher
`default_nettype none
`include "aes128_block_cipher_assert.svh"
module aes128_block_cipher_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] result_high_o,
  input wire logic [63:0] result_low_o
);
  `AES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `AES_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(result_high_o) && $stable(result_low_o))
  `AES_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `AES_ASSERT_IMPL(a_stall, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
endmodule

bind aes128_block_cipher aes128_block_cipher_checker u_chk (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .result_high_o, .result_low_o
);
`default_nettype wire
